@@ sv/confusion_matrix_mcc_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the confusion-matrix MCC block
// ---------------------------------------------------------------------------
`ifndef CONFUSION_MATRIX_MCC_DEFINES_SVH
`define CONFUSION_MATRIX_MCC_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define CMM_ASSERT_IMP(name, clk_s, rst_s, ante, cons, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define CMM_ASSERT_NXT(name, clk_s, rst_s, ante, cons, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/cmm_pkg.sv @@
// ---------------------------------------------------------------------------
// cmm_pkg
// Shared constants, label codes and queue status type for the MCC block.
// ---------------------------------------------------------------------------
package cmm_pkg;

    // Default width of each confusion count
    localparam int CMM_COUNT_BITS = 20;

    // Output field widths
    localparam int CMM_MCC_W = 16;
    localparam int CMM_PTC_W = 21;
    localparam int CMM_CNT_W = 20;

    // Fraction bits of the Q1.15 result
    localparam int CMM_FRAC_BITS = 15;

    // Entries in the queue between counting and arithmetic
    localparam int CMM_QDEPTH = 2;

    // Label codes
    typedef logic [1:0] cmm_label_t;
    localparam cmm_label_t LBL_NEG = 2'd0;
    localparam cmm_label_t LBL_POS = 2'd1;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } cmm_qstat_t;

endpackage

@@ sv/cmm_front.sv @@
// ---------------------------------------------------------------------------
// cmm_front
// Classifies label pairs and keeps four saturating confusion counts; on the
// last pair of a set it pushes the final counts to the queue and clears.
// ---------------------------------------------------------------------------
module cmm_front
    import cmm_pkg::*;
#(
    parameter int COUNT_BITS = CMM_COUNT_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,    // [1:0] truth_code, [3:2] pred_code
    input  logic                    s_tlast,    // end_of_set
    input  cmm_qstat_t              q_stat,
    output logic                    push,
    output logic [4*COUNT_BITS-1:0] push_data
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    cmm_label_t            truth;
    cmm_label_t            pred;
    logic                  accept;
    logic                  hit_tp;
    logic                  hit_fp;
    logic                  hit_tn;
    logic                  hit_fn;
    logic [COUNT_BITS-1:0] tp_reg;
    logic [COUNT_BITS-1:0] fp_reg;
    logic [COUNT_BITS-1:0] tn_reg;
    logic [COUNT_BITS-1:0] fn_reg;
    logic [COUNT_BITS-1:0] tp_next;
    logic [COUNT_BITS-1:0] fp_next;
    logic [COUNT_BITS-1:0] tn_next;
    logic [COUNT_BITS-1:0] fn_next;

    assign truth    = s_tdata[1:0];
    assign pred     = s_tdata[3:2];
    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    // Classify the pair; other codes count nowhere
    assign hit_tp = (truth == LBL_POS) && (pred == LBL_POS);
    assign hit_fp = (truth == LBL_NEG) && (pred == LBL_POS);
    assign hit_tn = (truth == LBL_NEG) && (pred == LBL_NEG);
    assign hit_fn = (truth == LBL_POS) && (pred == LBL_NEG);

    // Saturating increments
    always_comb
    begin
        tp_next = (hit_tp && (tp_reg != CNT_MAX)) ? tp_reg + 1'b1 : tp_reg;
        fp_next = (hit_fp && (fp_reg != CNT_MAX)) ? fp_reg + 1'b1 : fp_reg;
        tn_next = (hit_tn && (tn_reg != CNT_MAX)) ? tn_reg + 1'b1 : tn_reg;
        fn_next = (hit_fn && (fn_reg != CNT_MAX)) ? fn_reg + 1'b1 : fn_reg;
    end

    // Hand the closing counts to the back end
    assign push      = accept && s_tlast;
    assign push_data = {fn_next, tn_next, fp_next, tp_next};

    // Update or clear the counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tp_reg <= '0;
            fp_reg <= '0;
            tn_reg <= '0;
            fn_reg <= '0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                tp_reg <= '0;
                fp_reg <= '0;
                tn_reg <= '0;
                fn_reg <= '0;
            end
            else
            begin
                tp_reg <= tp_next;
                fp_reg <= fp_next;
                tn_reg <= tn_next;
                fn_reg <= fn_next;
            end
        end
    end

endmodule

@@ sv/cmm_fifo.sv @@
// ---------------------------------------------------------------------------
// cmm_fifo
// Short queue of closed count sets between the front and the back end.
// ---------------------------------------------------------------------------
module cmm_fifo
    import cmm_pkg::*;
#(
    parameter int DW    = 4 * CMM_COUNT_BITS,
    parameter int DEPTH = CMM_QDEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    input  logic          pop,
    output logic [DW-1:0] pop_data,
    output cmm_qstat_t    stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem[rd_ptr_reg];

    // Store an entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ sv/cmm_back.sv @@
// ---------------------------------------------------------------------------
// cmm_back
// Sequencer that turns one set of counts into the MCC result: marginals,
// products on a shared multiplier, shift-add product, digit-by-digit square
// root and restoring division, then saturation into the output register.
// ---------------------------------------------------------------------------
`include "confusion_matrix_mcc_defines.svh"

module cmm_back
    import cmm_pkg::*;
#(
    parameter int COUNT_BITS = CMM_COUNT_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmm_qstat_t              q_stat,
    input  logic [4*COUNT_BITS-1:0] q_data,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [119:0]            m_tdata
);

    localparam int W   = COUNT_BITS + 1;          // marginal width
    localparam int PW  = 2 * W;                   // two-marginal product
    localparam int BW  = 4 * W;                   // four-marginal product
    localparam int SW  = 2 * W;                   // square root width
    localparam int RW  = SW + 2;                  // root remainder width
    localparam int MW  = 2 * COUNT_BITS;          // numerator magnitude
    localparam int DW  = SW + CMM_FRAC_BITS;      // divider width
    localparam int QW  = CMM_MCC_W;               // quotient bits
    localparam int IW  = $clog2(PW + 1);          // step counter
    localparam int OW  = CMM_MCC_W + CMM_PTC_W + 4 * CMM_CNT_W;

    localparam logic [QW-1:0] Q_POS_MAX = QW'((1 << (QW - 1)) - 1);
    localparam logic [QW-1:0] Q_NEG_MAX = QW'(1 << (QW - 1));

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MARG = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SIGN = 3'd3;
    localparam logic [2:0] S_BMUL = 3'd4;
    localparam logic [2:0] S_SQRT = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic [IW-1:0]         iter_reg;
    logic [IW-1:0]         iter_next;
    logic [COUNT_BITS-1:0] tp_reg;
    logic [COUNT_BITS-1:0] fp_reg;
    logic [COUNT_BITS-1:0] tn_reg;
    logic [COUNT_BITS-1:0] fn_reg;
    logic [W-1:0]          a_reg;
    logic [W-1:0]          b_reg;
    logic [W-1:0]          c_reg;
    logic [W-1:0]          d_reg;
    logic                  zero_reg;
    logic [MW-1:0]         pos_reg;
    logic [MW-1:0]         neg_reg;
    logic [PW-1:0]         ab_reg;
    logic [PW-1:0]         cd_reg;
    logic                  negflag_reg;
    logic [BW-1:0]         mcand_reg;
    logic [PW-1:0]         mplier_reg;
    logic [BW-1:0]         acc_reg;
    logic [RW-1:0]         rem_reg;
    logic [SW-1:0]         root_reg;
    logic [DW-1:0]         drem_reg;
    logic [DW-1:0]         dvs_reg;
    logic [QW-1:0]         q_reg;
    logic                  out_valid_reg;
    logic [OW-1:0]         out_data_reg;

    logic [W-1:0]          mul_a;
    logic [W-1:0]          mul_b;
    logic [PW-1:0]         mul_p;
    logic [MW-1:0]         mag;
    logic [RW-1:0]         rem_sh;
    logic [RW-1:0]         trial;
    logic                  sq_ge;
    logic [RW-1:0]         rem_step;
    logic [SW-1:0]         root_step;
    logic                  dv_ge;
    logic [QW-1:0]         q_sat;
    logic [QW-1:0]         mcc_calc;
    logic                  out_free;
    logic                  load_out;
    logic [OW-1:0]         out_word;

    // Shared multiplier: operands picked by step
    always_comb
    begin
        case (iter_reg[1:0])
            2'd0:
            begin
                mul_a = W'(tp_reg);
                mul_b = W'(tn_reg);
            end
            2'd1:
            begin
                mul_a = W'(fp_reg);
                mul_b = W'(fn_reg);
            end
            2'd2:
            begin
                mul_a = a_reg;
                mul_b = b_reg;
            end
            default:
            begin
                mul_a = c_reg;
                mul_b = d_reg;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Numerator magnitude
    assign mag = (pos_reg < neg_reg) ? neg_reg - pos_reg : pos_reg - neg_reg;

    // One square-root digit
    assign rem_sh    = {rem_reg[RW-3:0], acc_reg[BW-1:BW-2]};
    assign trial     = {root_reg, 2'b01};
    assign sq_ge     = (rem_sh >= trial);
    assign rem_step  = sq_ge ? rem_sh - trial : rem_sh;
    assign root_step = {root_reg[SW-2:0], sq_ge};

    // One quotient bit
    assign dv_ge = (drem_reg >= dvs_reg);

    // Saturate and apply the sign
    always_comb
    begin
        if (negflag_reg)
        begin
            q_sat    = (q_reg > Q_NEG_MAX) ? Q_NEG_MAX : q_reg;
            mcc_calc = QW'(-q_sat);
        end
        else
        begin
            q_sat    = (q_reg > Q_POS_MAX) ? Q_POS_MAX : q_reg;
            mcc_calc = q_sat;
        end
    end

    // Output word, fields from the highest bit down
    assign out_word = {CMM_CNT_W'(fn_reg), CMM_CNT_W'(tn_reg),
                       CMM_CNT_W'(fp_reg), CMM_CNT_W'(tp_reg),
                       CMM_PTC_W'({1'b0, tp_reg} + {1'b0, fn_reg}),
                       mcc_calc};

    assign out_free = !out_valid_reg || m_tready;
    assign load_out = (state_reg == S_FIN) && out_free;
    assign pop      = (state_reg == S_IDLE) && !q_stat.empty;

    // Sequencer state and step count
    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = S_MARG;
                end
            end
            S_MARG:
            begin
                state_next = S_MUL;
                iter_next  = '0;
            end
            S_MUL:
            begin
                iter_next = iter_reg + 1'b1;
                if (iter_reg == IW'(3))
                begin
                    state_next = S_SIGN;
                end
            end
            S_SIGN:
            begin
                iter_next  = '0;
                state_next = zero_reg ? S_FIN : S_BMUL;
            end
            S_BMUL:
            begin
                iter_next = iter_reg + 1'b1;
                if (iter_reg == IW'(PW - 1))
                begin
                    state_next = S_SQRT;
                    iter_next  = '0;
                end
            end
            S_SQRT:
            begin
                iter_next = iter_reg + 1'b1;
                if (iter_reg == IW'(SW - 1))
                begin
                    state_next = S_DIV;
                    iter_next  = '0;
                end
            end
            S_DIV:
            begin
                iter_next = iter_reg + 1'b1;
                if (iter_reg == IW'(QW - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                {fn_reg, tn_reg, fp_reg, tp_reg} <= q_data;
            end
            S_MARG:
            begin
                a_reg    <= {1'b0, tp_reg} + {1'b0, fp_reg};
                b_reg    <= {1'b0, tp_reg} + {1'b0, fn_reg};
                c_reg    <= {1'b0, tn_reg} + {1'b0, fp_reg};
                d_reg    <= {1'b0, tn_reg} + {1'b0, fn_reg};
                zero_reg <= (tp_reg == '0 && fp_reg == '0) || (tp_reg == '0 && fn_reg == '0)
                         || (tn_reg == '0 && fp_reg == '0) || (tn_reg == '0 && fn_reg == '0);
            end
            S_MUL:
            begin
                case (iter_reg[1:0])
                    2'd0:    pos_reg <= MW'(mul_p);
                    2'd1:    neg_reg <= MW'(mul_p);
                    2'd2:    ab_reg  <= mul_p;
                    default: cd_reg  <= mul_p;
                endcase
            end
            S_SIGN:
            begin
                negflag_reg <= !zero_reg && (pos_reg < neg_reg);
                q_reg       <= '0;
                drem_reg    <= DW'(mag) << CMM_FRAC_BITS;
                mcand_reg   <= BW'(ab_reg);
                mplier_reg  <= cd_reg;
                acc_reg     <= '0;
            end
            S_BMUL:
            begin
                if (mplier_reg[0])
                begin
                    acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                rem_reg    <= '0;
                root_reg   <= '0;
            end
            S_SQRT:
            begin
                acc_reg  <= acc_reg << 2;
                rem_reg  <= rem_step;
                root_reg <= root_step;
                dvs_reg  <= DW'(root_step) << CMM_FRAC_BITS;
            end
            S_DIV:
            begin
                if (dv_ge)
                begin
                    drem_reg <= drem_reg - dvs_reg;
                end
                dvs_reg <= dvs_reg >> 1;
                q_reg   <= {q_reg[QW-2:0], dv_ge};
            end
            S_FIN:
            begin
                if (load_out)
                begin
                    out_data_reg <= out_word;
                end
            end
            default:
            begin
                q_reg <= q_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 120'(out_data_reg);

    // Checks
    `CMM_ASSERT_IMP(a_pop_nonempty, clk, rst_n, pop, !q_stat.empty, "pop from empty queue")
    `CMM_ASSERT_IMP(a_sqrt_rem_bound, clk, rst_n, state_reg == S_SQRT,
        rem_reg <= (RW'(root_reg) << 1), "square root remainder out of bound")
    `CMM_ASSERT_IMP(a_zero_marginal, clk, rst_n, (state_reg == S_FIN) && zero_reg,
        mcc_calc == '0, "zero marginal must give zero coefficient")
    `CMM_ASSERT_IMP(a_valid_from_fin, clk, rst_n, $rose(m_tvalid),
        $past(state_reg) == S_FIN, "result shown without finishing the sequence")

endmodule

@@ sv/confusion_matrix_mcc.sv @@
// A set with a zero marginal skips the product, square root and division.
// Throughput: one label pair per cycle while the queue is not full; the
// arithmetic sequencer runs its shift-add product, square root and 16-step
// division once per set whose marginals are all nonzero.
// A two-entry queue of closed sets stalls input only when full.
// Reset: asynchronous, active low; clears counts, queue and output valid.
// ---------------------------------------------------------------------------
// confusion_matrix_mcc
// Counts a confusion matrix over streamed label pairs and emits the Matthews
// correlation coefficient in Q1.15 with the counts at the end of each set.
// ---------------------------------------------------------------------------
module confusion_matrix_mcc
    import cmm_pkg::*;
#(
    parameter int COUNT_BITS = CMM_COUNT_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [1:0] truth_code, [3:2] pred_code
    input  logic         s_tlast,   // end_of_set
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata    // [15:0] mcc_q15, [36:16] positive_test_count,
                                    // [56:37] true_pos, [76:57] false_pos,
                                    // [96:77] true_neg, [116:97] false_neg
);

    localparam int QDW = 4 * COUNT_BITS;

    cmm_qstat_t     q_stat;
    logic           push;
    logic [QDW-1:0] push_data;
    logic           pop;
    logic [QDW-1:0] pop_data;

    // Count and classify
    cmm_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    // Hold closed sets
    cmm_fifo #(
        .DW    (QDW),
        .DEPTH (CMM_QDEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    // Compute the coefficient
    cmm_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .q_data   (pop_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
